// ----- rtl/core/lzfb_pkg.sv -----
`default_nettype none
package lzfb_pkg;
   typedef enum logic [3:0] {
      PH_CONTROL  = 4'b0001,
      PH_FLAGS    = 4'b0010,
      PH_DISTANCE = 4'b0100,
      PH_COPY     = 4'b1000
   } phase_type;

   localparam logic [8:0] MAX_MATCH_LEN = 9'd256;
   localparam int         OUT_BYTES     = 4;
endpackage
`default_nettype wire

// ----- rtl/core/lz_flag_byte_decompressor_top.sv -----
// Timing: a literal's result is registered, valid in the cycle after its transfer; a match
//   copies each byte from history back at wp and packs up to four bytes per result.
// Throughput: one byte per cycle for control, length and literal bytes while the receiver
//   keeps up; a match holds input through its copy (read, write back per byte) and stalls.
// Reset: synchronous, active high. The history RAM is not cleared; per-entry valid bits
//   make unwritten entries read as 0xFF.
`default_nettype none
module lz_flag_byte_decompressor_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_in_byte,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [2:0] rsp_byte_count,
   output logic       rsp_last_of_run,
   output logic       rsp_stream_end
);
   lzfb_pkg::phase_type phase_ff, phase_in;
   logic [7:0] flag_ff, flag_in;
   logic [8:0] len_ff, len_in;
   logic [7:0] wp_ff, wp_in;
   logic [7:0] src_ff, src_in;
   logic       fin_ff, fin_in;

   // history RAM with valid bits
   logic [7:0] ram [256];
   logic [255:0] vld_ff;
   logic [7:0]   rd_data_ff;
   logic         rd_vld_ff;
   logic         we;
   logic [7:0]   wa, wd;
   logic         re;
   logic [7:0]   ra;

   // copy sequencer: low to issue a read, high to write the byte back
   logic         rd_pend_ff, rd_pend_in;

   // output register
   logic [7:0] ob_ff [4];
   logic [7:0] ob_in [4];
   logic [2:0] cnt_ff, cnt_in;
   logic       ov_ff, ov_in, last_ff, last_in, end_ff, end_in;

   logic       acc;
   logic [7:0] rbyte;

   always_ff @(posedge clock) begin
      if (we) ram[wa] <= wd;
      if (re) begin
         rd_data_ff <= ram[ra];
         rd_vld_ff  <= vld_ff[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (we) vld_ff[wa] <= 1'b1;
   end

   assign rbyte = rd_vld_ff ? rd_data_ff : 8'hFF;
   assign acc = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff; flag_in = flag_ff; len_in = len_ff; wp_in = wp_ff;
      src_in = src_ff; fin_in = fin_ff; rd_pend_in = 1'b0;
      ob_in = ob_ff; cnt_in = cnt_ff; ov_in = ov_ff; last_in = last_ff; end_in = end_ff;
      we = 1'b0; wa = wp_ff; wd = req_in_byte; re = 1'b0; ra = src_ff;
      req_ready = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (phase_ff)
         lzfb_pkg::PH_CONTROL, lzfb_pkg::PH_FLAGS, lzfb_pkg::PH_DISTANCE: begin
            // take input only when a result could be stored, or once the stream has ended
            req_ready = fin_ff || !ov_ff || rsp_ready;
            if (acc && !fin_ff) begin
               if (phase_ff == lzfb_pkg::PH_CONTROL) begin
                  if (req_in_byte == 8'd0) begin
                     fin_in = 1'b1; ov_in = 1'b1; cnt_in = 3'd0; last_in = 1'b1;
                     end_in = 1'b1;
                     for (int i = 0; i < 4; i++) ob_in[i] = 8'd0;
                  end else begin
                     flag_in = req_in_byte;
                     phase_in = (req_in_byte > 8'd1) ? lzfb_pkg::PH_FLAGS
                                                      : lzfb_pkg::PH_CONTROL;
                  end
               end else if (phase_ff == lzfb_pkg::PH_FLAGS) begin
                  if (flag_ff[0]) begin
                     we = 1'b1; wp_in = wp_ff + 8'd1;
                     ov_in = 1'b1; cnt_in = 3'd1; last_in = 1'b1; end_in = 1'b0;
                     ob_in[0] = req_in_byte;
                     for (int i = 1; i < 4; i++) ob_in[i] = 8'd0;
                     flag_in = {1'b0, flag_ff[7:1]};
                     phase_in = (flag_ff[7:1] > 7'd1) ? lzfb_pkg::PH_FLAGS
                                                       : lzfb_pkg::PH_CONTROL;
                  end else begin
                     len_in = (req_in_byte == 8'd0) ? lzfb_pkg::MAX_MATCH_LEN
                                                    : {1'b0, req_in_byte};
                     phase_in = lzfb_pkg::PH_DISTANCE;
                  end
               end else begin
                  // source = wp - dist = wp + d (mod 256)
                  src_in = wp_ff + req_in_byte;
                  cnt_in = 3'd0;
                  phase_in = lzfb_pkg::PH_COPY;
               end
            end
         end
         lzfb_pkg::PH_COPY: begin
            // one byte per two-step: read source, then write it back at wp
            if (!rd_pend_ff) begin
               // hold while a finished result waits; start a fresh one once it is taken
               if (!ov_ff || rsp_ready) begin
                  re = 1'b1; ra = src_ff; rd_pend_in = 1'b1;
                  if (ov_ff) cnt_in = 3'd0;
               end
            end else begin
               // the output is always free here: a read is only issued once it drains
               we = 1'b1; wa = wp_ff; wd = rbyte;
               wp_in = wp_ff + 8'd1; src_in = src_ff + 8'd1;
               ob_in[cnt_ff[1:0]] = rbyte;
               if (cnt_ff == 3'd0) for (int i = 1; i < 4; i++) ob_in[i] = 8'd0;
               len_in = len_ff - 9'd1;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff + 3'd1 == 3'(lzfb_pkg::OUT_BYTES) || len_ff == 9'd1) begin
                  ov_in = 1'b1; last_in = (len_ff == 9'd1); end_in = 1'b0;
               end
               if (len_ff == 9'd1) begin
                  flag_in = {1'b0, flag_ff[7:1]};
                  phase_in = (flag_ff[7:1] > 7'd1) ? lzfb_pkg::PH_FLAGS
                                                    : lzfb_pkg::PH_CONTROL;
               end
            end
         end
         default: phase_in = lzfb_pkg::PH_CONTROL;
      endcase
   end

   // advance the control state; payload registers need no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lzfb_pkg::PH_CONTROL; flag_ff <= '0; len_ff <= '0; wp_ff <= '0;
         fin_ff <= 1'b0; ov_ff <= 1'b0; rd_pend_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in; flag_ff <= flag_in; len_ff <= len_in; wp_ff <= wp_in;
         fin_ff <= fin_in; ov_ff <= ov_in; rd_pend_ff <= rd_pend_in; cnt_ff <= cnt_in;
      end
      src_ff <= src_in; last_ff <= last_in; end_ff <= end_in;
      for (int i = 0; i < 4; i++) ob_ff[i] <= ob_in[i];
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_byte0   = ob_ff[0];
   assign rsp_out_byte1   = ob_ff[1];
   assign rsp_out_byte2   = ob_ff[2];
   assign rsp_out_byte3   = ob_ff[3];
   assign rsp_byte_count  = cnt_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_stream_end  = end_ff;

   a_no_input_in_copy: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lzfb_pkg::PH_COPY |-> !req_ready) else $error("input taken during copy");
   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_byte_count == 3'd0) else $error("end with bytes");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte0))
      else $error("result dropped");
endmodule
`default_nettype wire

// ----- tb/sv/lz_flag_byte_decompressor_top_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lz_flag_byte_decompressor_top_test;

   // Abandon the run after this many cycles without a single transfer on
   // either channel.
   localparam int STALL_LIMIT = 20000;
   // Allow this many cycles for the block to drain after the last expected result.
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [2:0] cnt;
      logic       last;
      logic       fin;
   } chunk_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [7:0] rsp_out_byte3;
   logic [2:0] rsp_byte_count;
   logic       rsp_last_of_run;
   logic       rsp_stream_end;

   lz_flag_byte_decompressor_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte0(rsp_out_byte0), .rsp_out_byte1(rsp_out_byte1),
      .rsp_out_byte2(rsp_out_byte2), .rsp_out_byte3(rsp_out_byte3),
      .rsp_byte_count(rsp_byte_count), .rsp_last_of_run(rsp_last_of_run),
      .rsp_stream_end(rsp_stream_end)
   );

   // Decoder mirror: its own copy of the block's decoding state and history.
   lzfb_pkg::phase_type dec_phase;
   logic [7:0] dec_flags;
   logic [8:0] dec_len;
   logic [7:0] dec_hist [256];
   logic [7:0] dec_wp;
   logic       dec_done;

   chunk_type  pending_chunks [$];
   int         idle_pct;
   int         stall_pct;
   int         hold_cycles;
   int         bytes_sent;
   int         chunks_seen;
   int         mismatches;
   int         quiet_cycles;
   int         long_matches;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Queue one result of the decoder mirror.
   task automatic push_chunk(input logic [7:0] bb [4], input int fill, input logic last,
                             input logic fin);
      chunk_type c;
      c.b0   = (fill > 0) ? bb[0] : 8'h00;
      c.b1   = (fill > 1) ? bb[1] : 8'h00;
      c.b2   = (fill > 2) ? bb[2] : 8'h00;
      c.b3   = (fill > 3) ? bb[3] : 8'h00;
      c.cnt  = fill[2:0];
      c.last = last;
      c.fin  = fin;
      pending_chunks.push_back(c);
   endtask

   // Shift the served flag out; drop back to the control phase when only the
   // sentinel remains.
   task automatic next_flag();
      dec_flags = dec_flags >> 1;
      dec_phase = (dec_flags > 8'd1) ? lzfb_pkg::PH_FLAGS : lzfb_pkg::PH_CONTROL;
   endtask

   // Advance the mirror by one transferred input byte.
   task automatic decode_byte(input logic [7:0] b);
      logic [7:0] bb [4];
      logic [7:0] v;
      int         span;
      int         fill;
      int         done;
      if (dec_done) return;
      bb = '{default: 8'h00};
      if (dec_phase == lzfb_pkg::PH_FLAGS) begin
         if (dec_flags[0]) begin
            bb[0] = b;
            dec_hist[dec_wp] = b;
            dec_wp++;
            push_chunk(bb, 1, 1'b1, 1'b0);
            next_flag();
         end else begin
            dec_len   = (b == 8'd0) ? lzfb_pkg::MAX_MATCH_LEN : {1'b0, b};
            dec_phase = lzfb_pkg::PH_DISTANCE;
         end
      end else if (dec_phase == lzfb_pkg::PH_DISTANCE) begin
         span = (b == 8'd0) ? 256 : 256 - int'(b);
         fill = 0;
         done = 0;
         while (done < int'(dec_len)) begin
            v = dec_hist[8'(int'(dec_wp) + 256 - span)];
            dec_hist[dec_wp] = v;
            dec_wp++;
            bb[fill] = v;
            fill++;
            done++;
            if (fill == 4 || done == int'(dec_len)) begin
               push_chunk(bb, fill, done == int'(dec_len), 1'b0);
               fill = 0;
               bb = '{default: 8'h00};
            end
         end
         dec_len = '0;
         next_flag();
      end else begin
         if (b == 8'd0) begin
            dec_done = 1'b1;
            push_chunk(bb, 0, 1'b1, 1'b1);
         end else begin
            dec_flags = b;
            dec_phase = (b > 8'd1) ? lzfb_pkg::PH_FLAGS : lzfb_pkg::PH_CONTROL;
         end
      end
   endtask

   // Offer one byte, idling first at the current rate, and hold it until the
   // transfer happens. Called and left at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      decode_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // One well-formed block: a control byte and the literals and matches it calls for.
   task automatic send_block(input bit long_ok);
      logic [7:0] ctl;
      logic [7:0] f;
      ctl = ($urandom_range(9) == 0) ? 8'h01 : 8'($urandom_range(255, 1));
      send_byte(ctl);
      f = ctl;
      while (f > 8'd1) begin
         if (f[0]) begin
            send_byte(8'($urandom_range(255)));
         end else begin
            if (long_ok && $urandom_range(9) == 0) begin
               send_byte(8'($urandom_range(255)));
               long_matches++;
            end else begin
               send_byte(8'($urandom_range(12, 1)));
            end
            send_byte(8'($urandom_range(255)));
         end
         f = f >> 1;
      end
   endtask

   task automatic run_blocks(input int n_bytes);
      int target;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) send_block(1'b1);
      req_valid <= 1'b0;
   endtask

   // Receiver: stall at the current rate, or hold off for a counted stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each result transfer with the oldest expectation; watch for a hang.
   always @(posedge clock) begin
      chunk_type got;
      chunk_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("lz_flag_byte_decompressor_top_test: errors");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_byte3,
                    rsp_byte_count, rsp_last_of_run, rsp_stream_end};
            chunks_seen++;
            if (pending_chunks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = pending_chunks.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d: bytes %h %h %h %h cnt %0d last %b end %b",
                              chunks_seen, got.b0, got.b1, got.b2, got.b3, got.cnt,
                              got.last, got.fin);
                     $display("   want: bytes %h %h %h %h cnt %0d last %b end %b",
                              want.b0, want.b1, want.b2, want.b3,
                              want.cnt, want.last, want.fin);
                  end
               end
            end
         end
      end
   end

   // Unwritten history, a run of seven literals, copies at distance one and two (the
   // second overlapping), a full-window copy of maximum length, empty control.
   task automatic test_directed();
      send_byte(8'h01);
      send_byte(8'h02); send_byte(8'd5); send_byte(8'hFB);
      send_byte(8'hFF);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'hAA); send_byte(8'h55);
      send_byte(8'h01); send_byte(8'h80); send_byte(8'h7E);
      send_byte(8'h04);
      send_byte(8'd1); send_byte(8'hFF);
      send_byte(8'd0); send_byte(8'h00);
      send_byte(8'h05);
      send_byte(8'h12);
      send_byte(8'd9); send_byte(8'hFE);
      req_valid <= 1'b0;
   endtask

   task automatic test_random(input int ipct, input int spct, input int n_bytes);
      idle_pct  = ipct;
      stall_pct = spct;
      run_blocks(n_bytes);
   endtask

   // Hold the receiver off while the sender offers two matches, then literals.
   task automatic test_backpressure();
      idle_pct    = 0;
      stall_pct   = 0;
      hold_cycles = 1500;
      send_byte(8'h02); send_byte(8'd200); send_byte(8'd0);
      send_byte(8'hFE);
      send_byte(8'h33); send_byte(8'h44); send_byte(8'h55);
      send_byte(8'h66); send_byte(8'h77); send_byte(8'h88); send_byte(8'h99);
      req_valid <= 1'b0;
   endtask

   // Close the stream, then offer bytes that must be swallowed silently.
   task automatic test_stream_end();
      idle_pct  = 30;
      stall_pct = 30;
      while (dec_phase != lzfb_pkg::PH_CONTROL) send_byte(8'($urandom_range(255)));
      send_byte(8'h00);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h5A);
      req_valid <= 1'b0;
   endtask

   initial begin
      int w;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_byte  = 8'h00;
      rsp_ready    = 1'b0;
      dec_phase    = lzfb_pkg::PH_CONTROL;
      dec_flags    = '0;
      dec_len      = '0;
      dec_hist     = '{default: 8'hFF};
      dec_wp       = '0;
      dec_done     = 1'b0;
      idle_pct     = 0;
      stall_pct    = 0;
      hold_cycles  = 0;
      bytes_sent   = 0;
      chunks_seen  = 0;
      mismatches   = 0;
      quiet_cycles = 0;
      long_matches = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(0, 0, 55);
      test_random(64, 0, 55);
      test_random(0, 64, 55);
      test_random(30, 30, 55);
      test_backpressure();
      test_stream_end();
      w = 0;
      while (pending_chunks.size() != 0 && w < STALL_LIMIT) begin
         @(posedge clock);
         w++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d input bytes, %0d results, %0d long matches, %0d mismatches",
               bytes_sent, chunks_seen, long_matches, mismatches);
      $display("idle, stall and hold-off phases run; stream closed and trailing bytes ignored");
      if (mismatches == 0 && pending_chunks.size() == 0) begin
         $display("lz_flag_byte_decompressor_top_test: clean");
      end else begin
         $display("lz_flag_byte_decompressor_top_test: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- lz_flag_byte_decompressor_top.f -----
rtl/core/lzfb_pkg.sv
rtl/core/lz_flag_byte_decompressor_top.sv
tb/sv/lz_flag_byte_decompressor_top_test.sv
